[rtl/core/doeq_pkg.sv]
// ----------------------------------------------------------------------------
// doeq_pkg
// Shared types and constants of the deadline ordered event queue.
// ----------------------------------------------------------------------------
package doeq_pkg;

    localparam int QueueDepth = 64;
    localparam int AddrW      = $clog2(QueueDepth);
    localparam int CntW       = $clog2(QueueDepth + 1);

    localparam logic [29:0] NsecPerSec = 30'd1000000000;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_PEEK   = 2'd1,
        FN_GROUP  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_EVENT    = 2'd2,
        ST_NOEVENT  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_PEEK,
        S_GRP_REF,
        S_GRP_RD,
        S_GRP_CHK,
        S_GRP_FLUSH,
        S_CPY_RD,
        S_CPY_WR,
        S_EMIT_ST
    } t_state;

    // times packed as secs*2^30 + nsecs
    typedef struct packed {
        logic [61:0] deadline;
        logic [61:0] stamp;
        logic [15:0] microstep;
        logic [15:0] level;
        logic [7:0]  actor;
        logic [63:0] payload;
        logic [61:0] offset;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic        last;
        logic [61:0] deadline;
        logic [61:0] stamp;
        logic [15:0] microstep;
        logic [15:0] level;
        logic [7:0]  actor;
        logic [63:0] payload;
        logic [31:0] safe_secs;
        logic [29:0] safe_nsecs;
    } t_result;

    // new key sorts in front of stored key
    function automatic logic key_le(input t_entry a, input t_entry b);
        return {a.deadline, a.stamp, a.microstep, a.level}
            <= {b.deadline, b.stamp, b.microstep, b.level};
    endfunction

endpackage

[rtl/core/deadline_ordered_event_queue.sv]
// ----------------------------------------------------------------------------
// deadline_ordered_event_queue
// Sorted event queue keyed by deadline, timestamp, microstep and level.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries commands: tuser is the function (insert,
//   peek, remove tag group), tdata the position and the event to insert.
//   Master channel m_axis_* returns result beats: tuser is the status,
//   tlast marks the final beat of a command.
//   Events live in one entry memory kept in queue order (rank 0 is head),
//   single registered read port plus one write port.
//   Insert walks from the tail toward the insertion point, moving one entry
//   per step. Group removal scans the tag run, then compacts the entries
//   behind it.
//   One command is in flight at a time; s_axis_tready is high when idle.
//   Results sit in an output register, so a new command is taken while the
//   last beat waits. A stalled receiver holds the scan at the next beat.
//   Reset empties the queue at once (memory contents need no clearing).
// ----------------------------------------------------------------------------
module deadline_ordered_event_queue import doeq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // position, dl_secs, dl_nsecs, st_secs, st_nsecs, microstep, level,
    // actor, off_secs, off_nsecs, payload
    input  logic [295:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dl_secs, dl_nsecs, st_secs, st_nsecs, microstep, level, actor,
    // payload, safe_secs, safe_nsecs, zero pad
    output logic [295:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    // entry memory, queue order
    t_entry mem [QueueDepth];
    t_entry r_rd;

    logic             rd_en, wr_en;
    logic [AddrW-1:0] rd_addr, wr_addr;
    t_entry           wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;   // occupancy
    logic [CntW-1:0] r_r, n_r;       // read rank
    logic [CntW-1:0] r_w, n_w;       // write rank during compaction
    t_entry          r_new, n_new;
    t_entry          r_ref, n_ref;
    t_entry          r_pend, n_pend; // beat held back until we know if last
    t_status         r_st, n_st;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    t_entry  f_entry;
    t_status f_status;
    logic    f_last;
    t_result f_res;

    doeq_fmt u_fmt (
        .i_entry  (f_entry),
        .i_status (f_status),
        .i_last   (f_last),
        .o_result (f_res)
    );

    logic   emit_ok;
    logic   accept;
    t_func  in_func;
    logic   [5:0] in_pos;
    logic   pos_ok;
    t_entry in_entry;

    always_comb begin
        emit_ok  = !r_out_valid || m_axis_tready;
        accept   = s_axis_tvalid && s_axis_tready;
        in_func  = t_func'(s_axis_tuser);
        in_pos   = s_axis_tdata[5:0];
        pos_ok   = 32'(in_pos) < 32'(r_cnt);
        in_entry.deadline  = {s_axis_tdata[37:6],    s_axis_tdata[67:38]};
        in_entry.stamp     = {s_axis_tdata[99:68],   s_axis_tdata[129:100]};
        in_entry.microstep = s_axis_tdata[145:130];
        in_entry.level     = s_axis_tdata[161:146];
        in_entry.actor     = s_axis_tdata[169:162];
        in_entry.offset    = {s_axis_tdata[201:170], s_axis_tdata[231:202]};
        in_entry.payload   = s_axis_tdata[295:232];
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_r    <= n_r;
        r_w    <= n_w;
        r_new  <= n_new;
        r_ref  <= n_ref;
        r_pend <= n_pend;
        r_st   <= n_st;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_r         = r_r;
        n_w         = r_w;
        n_new       = r_new;
        n_ref       = r_ref;
        n_pend      = r_pend;
        n_st        = r_st;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_r[AddrW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_r[AddrW-1:0];
        wr_data     = r_rd;
        f_entry     = r_pend;
        f_status    = ST_EVENT;
        f_last      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        FN_INSERT: begin
                            if (r_cnt >= CntW'(QueueDepth)) begin
                                n_st    = ST_FULL;
                                n_state = S_EMIT_ST;
                            end else begin
                                n_new   = in_entry;
                                n_r     = r_cnt;
                                n_state = S_INS_RD;
                            end
                        end
                        FN_PEEK: begin
                            if (pos_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = AddrW'(in_pos);
                                n_state = S_PEEK;
                            end else begin
                                n_st    = ST_NOEVENT;
                                n_state = S_EMIT_ST;
                            end
                        end
                        FN_GROUP: begin
                            if (pos_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = AddrW'(in_pos);
                                n_w     = CntW'(in_pos);
                                n_r     = CntW'(in_pos) + 1'b1;
                                n_state = S_GRP_REF;
                            end else begin
                                n_st    = ST_NOEVENT;
                                n_state = S_EMIT_ST;
                            end
                        end
                        default: begin
                            n_st    = ST_NOEVENT;
                            n_state = S_EMIT_ST;
                        end
                    endcase
                end
            end

            // walk from the tail, shifting keys equal to or larger than the new key up one rank
            S_INS_RD: begin
                if (r_r == '0) begin
                    n_state = S_INS_WR;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AddrW'(r_r - 1'b1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (key_le(r_new, r_rd)) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd;
                    n_r     = r_r - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                wr_en   = 1'b1;
                wr_data = r_new;
                n_cnt   = r_cnt + 1'b1;
                n_st    = ST_INSERTED;
                n_state = S_EMIT_ST;
            end

            S_PEEK: begin
                f_entry = r_rd;
                f_last  = 1'b1;
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out       = f_res;
                    n_state     = S_IDLE;
                end
            end

            S_GRP_REF: begin
                n_ref   = r_rd;
                n_pend  = r_rd;
                n_state = S_GRP_RD;
            end
            S_GRP_RD: begin
                if (r_r >= r_cnt) begin
                    n_state = S_GRP_FLUSH;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_GRP_CHK;
                end
            end
            S_GRP_CHK: begin
                if (r_rd.stamp != r_ref.stamp || r_rd.microstep != r_ref.microstep) begin
                    // tag run ends, entry at r_r is copied by the compaction pass
                    n_state = S_GRP_FLUSH;
                end else if (r_rd.actor == r_ref.actor) begin
                    if (emit_ok) begin
                        n_out_valid = 1'b1;
                        n_out       = f_res;
                        n_pend      = r_rd;
                        n_r         = r_r + 1'b1;
                        n_state     = S_GRP_RD;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_w[AddrW-1:0];
                    n_w     = r_w + 1'b1;
                    n_r     = r_r + 1'b1;
                    n_state = S_GRP_RD;
                end
            end
            S_GRP_FLUSH: begin
                f_last = 1'b1;
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out       = f_res;
                    n_state     = S_CPY_RD;
                end
            end
            S_CPY_RD: begin
                if (r_r >= r_cnt) begin
                    n_cnt   = r_w;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CPY_WR;
                end
            end
            S_CPY_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_w[AddrW-1:0];
                n_w     = r_w + 1'b1;
                n_r     = r_r + 1'b1;
                n_state = S_CPY_RD;
            end

            S_EMIT_ST: begin
                f_entry  = '0;
                f_status = r_st;
                f_last   = 1'b1;
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out       = f_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'b0, r_out.safe_nsecs, r_out.safe_secs, r_out.payload,
                            r_out.actor, r_out.level, r_out.microstep,
                            r_out.stamp[29:0], r_out.stamp[61:30],
                            r_out.deadline[29:0], r_out.deadline[61:30]};

endmodule

[rtl/core/doeq_fmt.sv]
// ----------------------------------------------------------------------------
// doeq_fmt
// Builds one result beat from an entry, including the safe time.
// ----------------------------------------------------------------------------
module doeq_fmt import doeq_pkg::*; (
    input  t_entry  i_entry,
    input  t_status i_status,
    input  logic    i_last,
    output t_result o_result
);

    logic [31:0] tsec, osec, ssec;
    logic [29:0] tns, ons;
    logic [30:0] nsd;
    logic        ge, borrow;

    always_comb begin
        tsec   = i_entry.stamp[61:30];
        tns    = i_entry.stamp[29:0];
        osec   = i_entry.offset[61:30];
        ons    = i_entry.offset[29:0];
        ge     = i_entry.stamp >= i_entry.offset;
        borrow = tns < ons;
        ssec   = tsec - osec - {31'b0, borrow};
        if (borrow) begin
            nsd = {1'b0, tns} + {1'b0, NsecPerSec} - {1'b0, ons};
        end else begin
            nsd = {1'b0, tns} - {1'b0, ons};
        end

        o_result.status     = i_status;
        o_result.last       = i_last;
        o_result.deadline   = i_entry.deadline;
        o_result.stamp      = i_entry.stamp;
        o_result.microstep  = i_entry.microstep;
        o_result.level      = i_entry.level;
        o_result.actor      = i_entry.actor;
        o_result.payload    = i_entry.payload;
        o_result.safe_secs  = ge ? ssec : 32'd0;
        o_result.safe_nsecs = ge ? nsd[29:0] : 30'd0;
    end

endmodule

[rtl/core/doeq_chk.sv]
// ----------------------------------------------------------------------------
// doeq_chk
// Port level checks of the event queue, bound to the top level.
// ----------------------------------------------------------------------------
module doeq_chk import doeq_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [295:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // only event beats can be followed by more beats of the same command
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_EVENT |-> m_axis_tlast)
        else $error("status beat without tlast");

    // status-only beats carry no event
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_EVENT |-> m_axis_tdata == '0)
        else $error("status beat with nonzero data");

    // reset drops the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind deadline_ordered_event_queue doeq_chk u_doeq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[verif/deadline_ordered_event_queue_test.sv]
// ----------------------------------------------------------------------------
// deadline_ordered_event_queue_test
// Self-checking bench for the deadline ordered event queue: a behavioral copy
// of the sorted queue predicts every result beat of insert, peek and tag-group
// removal commands, which are checked in order against the master channel.
// ----------------------------------------------------------------------------
module deadline_ordered_event_queue_test;
    import doeq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 300;

    // command beat fields
    typedef struct {
        logic [1:0]  func;
        logic [5:0]  position;
        logic [31:0] dl_secs;
        logic [29:0] dl_nsecs;
        logic [31:0] st_secs;
        logic [29:0] st_nsecs;
        logic [15:0] microstep;
        logic [15:0] level;
        logic [7:0]  actor;
        logic [31:0] off_secs;
        logic [29:0] off_nsecs;
        logic [63:0] payload;
    } t_cmd;

    // result beat as seen on the master channel
    typedef struct {
        logic [1:0]   status;
        logic         last;
        logic [295:0] data;
    } t_beat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [295:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    deadline_ordered_event_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---- shadow queue, kept directly in rank order ----
    t_entry q_ev[$];
    t_beat  expected_beats[$];
    t_cmd   pending_cmds[$];

    int  mismatches = 0;
    bit  hold_until_drained = 1'b0;   // sender pause requested by stimulus

    function automatic logic [61:0] pack_t(logic [31:0] s, logic [29:0] ns);
        return {s, ns};
    endfunction

    // safe time = stamp - offset, with nanosecond borrow; zero when negative
    function automatic logic [61:0] safe_time(t_entry e);
        logic [31:0] ss;
        logic [29:0] sn;
        logic [29:0] tns, ons;
        tns = e.stamp[29:0];
        ons = e.offset[29:0];
        ss = '0;
        sn = '0;
        if (e.stamp >= e.offset) begin
            ss = e.stamp[61:30] - e.offset[61:30];
            if (tns < ons) begin
                ss = ss - 32'd1;
                sn = 30'(tns + NsecPerSec - ons);
            end else begin
                sn = tns - ons;
            end
        end
        return {ss, sn};
    endfunction

    // secs below nsecs in every time field of the beat
    function automatic t_beat event_beat(t_entry e, logic last);
        t_beat       b;
        logic [61:0] sf;
        sf       = safe_time(e);
        b.status = ST_EVENT;
        b.last   = last;
        b.data   = {6'b0, sf[29:0], sf[61:30], e.payload, e.actor, e.level,
                    e.microstep, e.stamp[29:0], e.stamp[61:30],
                    e.deadline[29:0], e.deadline[61:30]};
        return b;
    endfunction

    function automatic t_beat flag_beat(t_status st);
        t_beat b;
        b.status = st;
        b.last   = 1'b1;
        b.data   = '0;
        return b;
    endfunction

    // updates the shadow queue and queues the result beats of one command
    function automatic void predict_queue_op(t_cmd c);
        t_entry e, ref_ev;
        t_entry kept[$];
        t_beat  out[$];
        int     k, r;
        if (c.func == FN_INSERT) begin
            if (q_ev.size() >= QueueDepth) begin
                expected_beats.push_back(flag_beat(ST_FULL));
                return;
            end
            e.deadline  = pack_t(c.dl_secs, c.dl_nsecs);
            e.stamp     = pack_t(c.st_secs, c.st_nsecs);
            e.microstep = c.microstep;
            e.level     = c.level;
            e.actor     = c.actor;
            e.payload   = c.payload;
            e.offset    = pack_t(c.off_secs, c.off_nsecs);
            k = 0;
            while (k < q_ev.size() &&
                   {e.deadline, e.stamp, e.microstep, e.level} >
                   {q_ev[k].deadline, q_ev[k].stamp, q_ev[k].microstep, q_ev[k].level})
                k++;
            q_ev.insert(k, e);
            expected_beats.push_back(flag_beat(ST_INSERTED));
            return;
        end
        if (c.func == 2'd3 || c.position >= q_ev.size()) begin
            expected_beats.push_back(flag_beat(ST_NOEVENT));
            return;
        end
        if (c.func == FN_PEEK) begin
            expected_beats.push_back(event_beat(q_ev[c.position], 1'b1));
            return;
        end
        // tag group removal
        ref_ev = q_ev[c.position];
        for (r = 0; r < c.position; r++) kept.push_back(q_ev[r]);
        out.push_back(event_beat(ref_ev, 1'b0));
        r = c.position + 1;
        while (r < q_ev.size() && q_ev[r].stamp == ref_ev.stamp &&
               q_ev[r].microstep == ref_ev.microstep) begin
            if (q_ev[r].actor == ref_ev.actor) out.push_back(event_beat(q_ev[r], 1'b0));
            else kept.push_back(q_ev[r]);
            r++;
        end
        for (; r < q_ev.size(); r++) kept.push_back(q_ev[r]);
        q_ev = kept;
        out[out.size()-1].last = 1'b1;
        foreach (out[i]) expected_beats.push_back(out[i]);
    endfunction

    // ---- driver ----
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_queue_op(pending_cmds.pop_front());
                src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (hold_until_drained && pending_cmds.size() > 0 && expected_beats.size() > 0
                && !(s_axis_tvalid && !s_axis_tready)) begin
                s_axis_tvalid <= 1'b0;   // sender paused until all results are back
            end else if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat
            end else if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_cmds[0].func;
                s_axis_tdata  <= {pending_cmds[0].payload, pending_cmds[0].off_nsecs,
                                  pending_cmds[0].off_secs, pending_cmds[0].actor,
                                  pending_cmds[0].level, pending_cmds[0].microstep,
                                  pending_cmds[0].st_nsecs, pending_cmds[0].st_secs,
                                  pending_cmds[0].dl_nsecs, pending_cmds[0].dl_secs,
                                  pending_cmds[0].position};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---- monitor ----
    int sink_gap = 0;
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_beat exp_b;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d data %h",
                                 m_axis_tuser, m_axis_tdata);
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (exp_b.status !== m_axis_tuser || exp_b.last !== m_axis_tlast ||
                        exp_b.data !== m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: exp st %0d last %0d data %h",
                                      " / got st %0d last %0d data %h"},
                                     exp_b.status, exp_b.last, exp_b.data,
                                     m_axis_tuser, m_axis_tlast, m_axis_tdata);
                    end
                end
                sink_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---- stimulus ----
    function automatic t_cmd rand_event(logic [31:0] st_s, logic [29:0] st_ns,
                                        logic [15:0] mi, logic [7:0] act);
        t_cmd c;
        c.func      = FN_INSERT;
        c.position  = 6'($urandom);
        c.dl_secs   = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4);
        c.dl_nsecs  = $urandom_range(0, 7) == 0 ? 30'($urandom)
                                                : 30'($urandom_range(0, 3));
        c.st_secs   = st_s;
        c.st_nsecs  = st_ns;
        c.microstep = mi;
        c.level     = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2));
        c.actor     = act;
        c.off_secs  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
        c.off_nsecs = $urandom_range(0, 7) == 0 ? 30'($urandom)
                                                : 30'($urandom_range(0, 999999999));
        c.payload   = {$urandom, $urandom};
        return c;
    endfunction

    function automatic t_cmd op_cmd(logic [1:0] f, logic [5:0] p);
        t_cmd c;
        c = rand_event($urandom, 30'($urandom), 16'($urandom), 8'($urandom));
        c.func = f;
        c.position = p;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || expected_beats.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    initial begin
        t_cmd c;
        int   n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queue peek/removal, unused code, extremes, safe time edges
        pending_cmds.push_back(op_cmd(FN_PEEK, 6'd0));
        pending_cmds.push_back(op_cmd(FN_GROUP, 6'd63));
        pending_cmds.push_back(op_cmd(2'd3, 6'd0));
        c = rand_event('1, '1, '1, '1);
        c.dl_secs = '1; c.dl_nsecs = '1; c.level = '1; c.payload = '1;
        c.off_secs = '0; c.off_nsecs = 30'd999999999;   // stamp nsecs above offset nsecs, so no borrow; odd nsecs
        pending_cmds.push_back(c);
        c = rand_event('0, '0, '0, '0);
        c.dl_secs = '0; c.dl_nsecs = '0; c.level = '0; c.payload = '0;
        c.off_secs = '0; c.off_nsecs = '0;
        pending_cmds.push_back(c);
        c = rand_event(32'd5, 30'd10, 16'd1, 8'd7);
        c.off_secs = 32'd6;                              // offset larger: safe time zero
        pending_cmds.push_back(c);
        c = rand_event(32'd5, 30'd10, 16'd1, 8'd7);
        c.off_secs = 32'd5; c.off_nsecs = 30'd10;        // exactly zero
        pending_cmds.push_back(c);
        pending_cmds.push_back(rand_event(32'd5, 30'd10, 16'd1, 8'd9));
        pending_cmds.push_back(op_cmd(FN_PEEK, 6'd0));
        pending_cmds.push_back(op_cmd(FN_PEEK, 6'd1));
        pending_cmds.push_back(op_cmd(FN_PEEK, 6'd4));
        pending_cmds.push_back(op_cmd(FN_PEEK, 6'd5));
        pending_cmds.push_back(op_cmd(FN_GROUP, 6'd0));
        pending_cmds.push_back(op_cmd(FN_GROUP, 6'd0));  // group at head again
        pending_cmds.push_back(op_cmd(2'd3, 6'd63));
        wait_drained();

        // fill to full, then further inserts that find it full
        hold_until_drained = 1'b1;
        for (n = 0; n < 66; n++)
            pending_cmds.push_back(rand_event(
                32'($urandom_range(0, 2)), 30'($urandom_range(0, 1)),
                16'($urandom_range(0, 1)), 8'($urandom_range(0, 2))));
        wait_drained();
        hold_until_drained = 1'b0;
        pending_cmds.push_back(op_cmd(FN_PEEK, 6'd63));
        pending_cmds.push_back(op_cmd(FN_GROUP, 6'd63));
        for (n = 0; n < 20; n++)
            pending_cmds.push_back(op_cmd(FN_GROUP, 6'($urandom_range(0, 5))));
        wait_drained();

        // random: clustered tags so that group runs appear
        for (n = 0; n < 67; n++) begin
            case ($urandom_range(0, 9)) inside
                [0:4]:   pending_cmds.push_back(rand_event(
                        32'($urandom_range(0, 2)), 30'($urandom_range(0, 1)),
                        16'($urandom_range(0, 1)), 8'($urandom_range(0, 2))));
                [5:6]:   pending_cmds.push_back(op_cmd(FN_PEEK, 6'($urandom_range(0, 20))));
                [7:8]:   pending_cmds.push_back(op_cmd(FN_GROUP, 6'($urandom_range(0, 20))));
                default: pending_cmds.push_back(op_cmd(2'($urandom), 6'($urandom)));
            endcase
            while (pending_cmds.size() > 4) @(posedge i_clk);
        end
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
